// File: src/doc_pkg.sv
// Shared types, codes and character classes for the directive operand checker.
// Used by doc_step and directive_operand_checker; depends on nothing else.
package doc_pkg;

	// Input request: one operand character and its line framing.
	typedef struct packed {
		logic [7:0] ch;
		logic       line_start;
		logic [1:0] kind;
	} doc_in_t;

	// Result request: one per input character.
	typedef struct packed {
		logic       keep;
		logic [7:0] out_char;
		logic       line_done;
		logic [3:0] error_code;
	} doc_out_t;

	typedef enum logic [9:0] {
		PH_IDLE    = 10'b00_0000_0001,
		PH_S_LEAD  = 10'b00_0000_0010,
		PH_S_IN    = 10'b00_0000_0100,
		PH_S_TAIL  = 10'b00_0000_1000,
		PH_N_LEAD  = 10'b00_0001_0000,
		PH_N_SIGN  = 10'b00_0010_0000,
		PH_N_DIG   = 10'b00_0100_0000,
		PH_N_AFTER = 10'b00_1000_0000,
		PH_N_COMMA = 10'b01_0000_0000,
		PH_OTHER   = 10'b10_0000_0000
	} phase_t;

	localparam logic [1:0] KIND_STRING  = 2'd0;
	localparam logic [1:0] KIND_NUMERIC = 2'd1;

	localparam logic [3:0] E_NONE       = 4'd0;
	localparam logic [3:0] E_UNCLOSED   = 4'd1;
	localparam logic [3:0] E_TRAILING   = 4'd2;
	localparam logic [3:0] E_NO_QUOTE   = 4'd3;
	localparam logic [3:0] E_EMPTY      = 4'd4;
	localparam logic [3:0] E_SIGN       = 4'd5;
	localparam logic [3:0] E_UNEXPECTED = 4'd6;
	localparam logic [3:0] E_DBL_COMMA  = 4'd7;
	localparam logic [3:0] E_EXPECT_NUM = 4'd8;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_COMMA = 8'd44;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic is_end(input logic [7:0] c);
		return (c == CH_NUL) || (c == CH_LF);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

endpackage

// File: src/doc_step.sv
// Per-character parser transition: next phase and result for one character.
// Purely combinational; depends on doc_pkg.
module doc_step (
	input  doc_pkg::doc_in_t  item,
	input  doc_pkg::phase_t   phase,
	output doc_pkg::phase_t   next_phase,
	output doc_pkg::doc_out_t res
);
	import doc_pkg::*;

	phase_t     ph;
	phase_t     cur;
	logic       keep;
	logic       done;
	logic [3:0] err;
	logic [7:0] c;

	assign c = item.ch;

	// A line start restarts the parser from the kind, dropping any open line.
	always_comb begin
		if (item.line_start) begin
			if (item.kind == KIND_STRING) begin
				cur = PH_S_LEAD;
			end else if (item.kind == KIND_NUMERIC) begin
				cur = PH_N_LEAD;
			end else begin
				cur = PH_OTHER;
			end
		end else begin
			cur = phase;
		end
	end

	always_comb begin
		ph   = cur;
		keep = 1'b0;
		done = 1'b0;
		err  = E_NONE;
		case (cur)
			PH_S_LEAD: begin
				if (is_blank(c)) begin
					ph = PH_S_LEAD;
				end else if (c == CH_QUOTE) begin
					ph = PH_S_IN;
				end else begin
					err = E_NO_QUOTE;
				end
			end
			PH_S_IN: begin
				if (c == CH_QUOTE) begin
					ph = PH_S_TAIL;
				end else if (is_end(c)) begin
					err = E_UNCLOSED;
				end else begin
					keep = 1'b1;
				end
			end
			PH_S_TAIL: begin
				if (is_end(c)) begin
					done = 1'b1;
				end else if (!is_blank(c)) begin
					err = E_TRAILING;
				end
			end
			PH_N_LEAD, PH_N_COMMA: begin
				if (is_blank(c)) begin
					ph = cur;
				end else if (is_end(c)) begin
					err = (cur == PH_N_LEAD) ? E_EMPTY : E_TRAILING;
				end else if ((cur == PH_N_COMMA) && (c == CH_COMMA)) begin
					err = E_DBL_COMMA;
				end else if (is_digit(c)) begin
					keep = 1'b1;
					ph   = PH_N_DIG;
				end else if (is_sign(c)) begin
					keep = 1'b1;
					ph   = PH_N_SIGN;
				end else begin
					err = E_EXPECT_NUM;
				end
			end
			PH_N_SIGN: begin
				if (is_digit(c)) begin
					keep = 1'b1;
					ph   = PH_N_DIG;
				end else begin
					err = E_SIGN;
				end
			end
			PH_N_DIG, PH_N_AFTER: begin
				if ((cur == PH_N_DIG) && is_digit(c)) begin
					keep = 1'b1;
				end else if (is_blank(c)) begin
					ph = PH_N_AFTER;
				end else if (c == CH_COMMA) begin
					keep = 1'b1;
					ph   = PH_N_COMMA;
				end else if (is_end(c)) begin
					done = 1'b1;
				end else begin
					err = E_UNEXPECTED;
				end
			end
			PH_OTHER: begin
				if (is_end(c)) begin
					done = 1'b1;
				end
			end
			default: begin
				ph = PH_IDLE;
			end
		endcase
	end

	assign next_phase     = (done || (err != E_NONE)) ? PH_IDLE : ph;
	assign res.keep       = keep;
	assign res.out_char   = keep ? c : 8'd0;
	assign res.line_done  = done;
	assign res.error_code = err;

endmodule

// File: src/directive_operand_checker.sv
// Top level of the directive operand checker: input register, parser phase,
// result register. Depends on doc_pkg and doc_step.
//
// Usage:
//   The char channel (char_valid, char_ready, char_data) takes one operand
//   character per request. Set line_start on the first character of a line;
//   kind is sampled only then (string, numeric list, other).
//   The res channel (res_valid, res_ready, res_data) returns exactly one
//   result request per character: the kept character, or on the character
//   that ends the line a line-done flag (NUL or newline) or an error code.
//   After a line ends, characters without line_start give all-zero results.
// Throughput:
//   A character goes from the input register to the result register. One
//   character per cycle is sustained while res_ready stays high; the phase
//   register is updated as a character moves between the two, so the next
//   character sees it in the following cycle.
// Reset:
//   arst_n clears both stage valids and returns the parser to idle.
// Stalls:
//   When a result waits and res_ready is low, the result register holds;
//   an empty input register takes one more character, then char_ready drops.
module directive_operand_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_ready,
	input  doc_pkg::doc_in_t  char_data,
	output logic              res_valid,
	input  logic              res_ready,
	output doc_pkg::doc_out_t res_data
);
	import doc_pkg::*;

	logic     valid_s1;
	doc_in_t  item_s1;
	phase_t   phase_q;
	phase_t   next_phase;
	doc_out_t step_res;
	logic     out_free;
	logic     advance;

	assign out_free   = !res_valid || res_ready;
	assign advance    = valid_s1 && out_free;
	assign char_ready = !valid_s1 || out_free;

	doc_step u_step (
		.item       (item_s1),
		.phase      (phase_q),
		.next_phase (next_phase),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			item_s1 <= char_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			res_valid <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= next_phase;
			end
			if (out_free) begin
				res_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_data <= step_res;
		end
	end

	// A line that ends returns the parser to idle for the next character.
	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (step_res.line_done || (step_res.error_code != E_NONE))
		|=> phase_q == PH_IDLE)
		else $error("parser not idle after line end");

	a_end_no_keep: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.line_done || (res_data.error_code != E_NONE))
		|-> !res_data.keep && (res_data.out_char == 8'd0))
		else $error("line-ending result keeps a character");

	a_done_xor_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.line_done && (res_data.error_code != E_NONE)))
		else $error("result both accepted and in error");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(phase_q) || !valid_s1)
		else $error("parser phase moved while result stalled");

endmodule

// File: dv/tb_directive_operand_checker.sv
`timescale 1ns / 100ps
// Self-checking testbench for directive_operand_checker: directed and random lines,
// predicted per character and compared against every result request.
// Depends on doc_pkg and the checker RTL.
module tb_directive_operand_checker;
	import doc_pkg::*;

	localparam logic [1:0] KIND_OTHER = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int NO_END = -1;
	localparam int RANDOM_CHARS = 1910;

	typedef logic [7:0] char_q_t[$];

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     char_valid = 1'b0;
	logic     char_ready;
	doc_in_t  char_data = '0;
	logic     res_valid;
	logic     res_ready = 1'b0;
	doc_out_t res_data;

	bit sender_pauses = 1'b1;
	bit receiver_stalls = 1'b1;

	// Predicted parser state.
	phase_t     parse_phase_q = PH_IDLE;

	doc_out_t expected_results[$];
	int chars_sent = 0;
	int lines_started = 0;
	int lines_accepted = 0;
	int lines_rejected = 0;
	int mismatch_count = 0;

	directive_operand_checker DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit blank_char(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic bit line_end_char(input logic [7:0] c);
		return c == CH_NUL || c == CH_LF;
	endfunction

	function automatic bit digit_char(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// Advances the predicted parser by one character and returns its result.
	function automatic doc_out_t predict_result(input doc_in_t req);
		doc_out_t   res;
		phase_t     ph;
		logic [7:0] c;
		logic       keep;
		logic       done;
		logic [3:0] err;
		c = req.ch;
		keep = 1'b0;
		done = 1'b0;
		err = E_NONE;
		if (req.line_start) begin
			case (req.kind)
				KIND_STRING:  parse_phase_q = PH_S_LEAD;
				KIND_NUMERIC: parse_phase_q = PH_N_LEAD;
				default:      parse_phase_q = PH_OTHER;
			endcase
		end
		ph = parse_phase_q;
		case (ph)
			PH_S_LEAD: begin
				if (c == CH_QUOTE) ph = PH_S_IN;
				else if (!blank_char(c)) err = E_NO_QUOTE;
			end
			PH_S_IN: begin
				if (c == CH_QUOTE) ph = PH_S_TAIL;
				else if (line_end_char(c)) err = E_UNCLOSED;
				else keep = 1'b1;
			end
			PH_S_TAIL: begin
				if (line_end_char(c)) done = 1'b1;
				else if (!blank_char(c)) err = E_TRAILING;
			end
			PH_N_LEAD, PH_N_COMMA: begin
				if (blank_char(c)) begin
				end else if (line_end_char(c)) begin
					err = (ph == PH_N_LEAD) ? E_EMPTY : E_TRAILING;
				end else if (ph == PH_N_COMMA && c == CH_COMMA) begin
					err = E_DBL_COMMA;
				end else if (digit_char(c)) begin
					keep = 1'b1;
					ph = PH_N_DIG;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					keep = 1'b1;
					ph = PH_N_SIGN;
				end else begin
					err = E_EXPECT_NUM;
				end
			end
			PH_N_SIGN: begin
				if (digit_char(c)) begin
					keep = 1'b1;
					ph = PH_N_DIG;
				end else begin
					err = E_SIGN;
				end
			end
			PH_N_DIG, PH_N_AFTER: begin
				if (ph == PH_N_DIG && digit_char(c)) begin
					keep = 1'b1;
				end else if (blank_char(c)) begin
					ph = PH_N_AFTER;
				end else if (c == CH_COMMA) begin
					keep = 1'b1;
					ph = PH_N_COMMA;
				end else if (line_end_char(c)) begin
					done = 1'b1;
				end else begin
					err = E_UNEXPECTED;
				end
			end
			PH_OTHER: begin
				if (line_end_char(c)) done = 1'b1;
			end
			default: ph = PH_IDLE;
		endcase
		if (done || err != E_NONE) ph = PH_IDLE;
		parse_phase_q = ph;
		res.keep = keep;
		res.out_char = keep ? c : 8'd0;
		res.line_done = done;
		res.error_code = err;
		return res;
	endfunction

	task automatic send_char(input doc_in_t req);
		doc_out_t res;
		if (sender_pauses && $urandom_range(99) < 24) begin
			char_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 24);
		end
		char_valid <= 1'b1;
		char_data <= req;
		do @(posedge clk); while (!char_ready);
		res = predict_result(req);
		expected_results.push_back(res);
		chars_sent++;
		if (req.line_start) lines_started++;
		if (res.line_done) lines_accepted++;
		if (res.error_code != E_NONE) lines_rejected++;
	endtask

	// The kind field only matters on the first character, so it is random elsewhere.
	task automatic send_bytes(input logic [1:0] kind, input char_q_t chars);
		foreach (chars[i])
			send_char('{ch: chars[i], line_start: (i == 0),
				kind: (i == 0) ? kind : 2'($urandom_range(3))});
	endtask

	task automatic send_line(input logic [1:0] kind, input string text, input int ending);
		char_q_t chars;
		for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
		if (ending != NO_END) chars.push_back(ending[7:0]);
		send_bytes(kind, chars);
	endtask

	function automatic logic [7:0] random_blank();
		return $urandom_range(1) ? CH_SPACE : CH_TAB;
	endfunction

	function automatic logic [7:0] random_text_char(input bit allow_quote);
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (line_end_char(c) || (!allow_quote && c == CH_QUOTE));
		return c;
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(6))
			0: return CH_QUOTE;
			1: return CH_COMMA;
			2: return $urandom_range(1) ? CH_PLUS : CH_MINUS;
			3: return $urandom_range(1) ? CH_NUL : CH_LF;
			4: return random_blank();
			5: return 8'(CH_ZERO + $urandom_range(9));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly well-formed lines with random content; a quarter are corrupted or cut short.
	task automatic send_random_line();
		char_q_t    text;
		logic [1:0] kind;
		int         entries;
		int         pos;
		case ($urandom_range(9))
			0, 1, 2, 3: kind = KIND_STRING;
			4, 5, 6, 7: kind = KIND_NUMERIC;
			8:          kind = KIND_OTHER;
			default:    kind = KIND_SPARE;
		endcase
		case (kind)
			KIND_STRING: begin
				repeat ($urandom_range(2)) text.push_back(random_blank());
				text.push_back(CH_QUOTE);
				repeat ($urandom_range(8)) text.push_back(random_text_char(1'b0));
				text.push_back(CH_QUOTE);
				repeat ($urandom_range(2)) text.push_back(random_blank());
			end
			KIND_NUMERIC: begin
				repeat ($urandom_range(2)) text.push_back(random_blank());
				entries = $urandom_range(1, 4);
				for (int n = 0; n < entries; n++) begin
					if (n != 0) begin
						text.push_back(CH_COMMA);
						repeat ($urandom_range(1)) text.push_back(random_blank());
					end
					if ($urandom_range(2) == 0)
						text.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
					repeat ($urandom_range(1, 3)) text.push_back(8'(CH_ZERO + $urandom_range(9)));
					repeat ($urandom_range(1)) text.push_back(random_blank());
				end
			end
			default: repeat ($urandom_range(6)) text.push_back(random_text_char(1'b1));
		endcase
		text.push_back($urandom_range(1) ? CH_NUL : CH_LF);
		if ($urandom_range(99) < 25) begin
			pos = $urandom_range(text.size() - 1);
			case ($urandom_range(2))
				0:       text[pos] = noise_char();
				1:       text.insert(pos, noise_char());
				default: text = text[0:pos];
			endcase
		end
		send_bytes(kind, text);
	endtask

	task automatic test_string_lines();
		send_line(KIND_STRING, "\t\"a\" ", CH_NUL);
		send_line(KIND_STRING, "\"", CH_LF);
		send_line(KIND_STRING, "\"\"x", NO_END);
	endtask

	task automatic test_numeric_lines();
		send_line(KIND_NUMERIC, "", CH_LF);
		send_line(KIND_NUMERIC, "+0, 9", CH_LF);
		send_line(KIND_NUMERIC, "1,,", NO_END);
		send_line(KIND_NUMERIC, "9,", CH_NUL);
		send_line(KIND_NUMERIC, "a", NO_END);
		send_line(KIND_NUMERIC, "1 2", NO_END);
	endtask

	task automatic test_other_lines();
		send_line(KIND_OTHER, "\377x", CH_LF);
		send_line(KIND_SPARE, "", CH_NUL);
	endtask

	task automatic test_restart_and_idle();
		send_char('{ch: 8'hFF, line_start: 1'b0, kind: KIND_SPARE});
		send_line(KIND_STRING, "\"\377", NO_END);
		// A new line start drops the open string; the sign then meets the line end.
		send_line(KIND_NUMERIC, "-", CH_NUL);
		send_line(KIND_STRING, "x", NO_END);
		send_char('{ch: CH_QUOTE, line_start: 1'b0, kind: KIND_STRING});
	endtask

	task automatic test_random_lines();
		int target;
		target = chars_sent + RANDOM_CHARS;
		while (chars_sent < target - 1150) send_random_line();
		sender_pauses = 1'b0;
		receiver_stalls = 1'b0;
		while (chars_sent < target - 650) send_random_line();
		sender_pauses = 1'b1;
		receiver_stalls = 1'b1;
		while (chars_sent < target) send_random_line();
	endtask

	always @(posedge clk or negedge arst_n) begin : result_check
		doc_out_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result with nothing expected: keep=%0b char=%02h done=%0b err=%0d",
							$time, res_data.keep, res_data.out_char, res_data.line_done,
							res_data.error_code);
				end else begin
					want = expected_results.pop_front();
					if (res_data.keep !== want.keep || res_data.out_char !== want.out_char ||
						res_data.line_done !== want.line_done ||
						res_data.error_code !== want.error_code) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"%0t: mismatch: expected keep=%0b char=%02h done=%0b err=%0d,",
								" got keep=%0b char=%02h done=%0b err=%0d"}, $time,
								want.keep, want.out_char, want.line_done, want.error_code,
								res_data.keep, res_data.out_char, res_data.line_done,
								res_data.error_code);
					end
				end
			end
			res_ready <= !(receiver_stalls && $urandom_range(99) < 24);
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_restart_and_idle();
		test_string_lines();
		test_numeric_lines();
		test_other_lines();
		test_random_lines();
		char_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Checked %0d characters over %0d lines: %0d accepted, %0d ended in an error.",
			chars_sent, lines_started, lines_accepted, lines_rejected);
		$display("Result mismatches: %0d.", mismatch_count);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Run timed out.");
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
src/doc_pkg.sv
src/doc_step.sv
src/directive_operand_checker.sv
dv/tb_directive_operand_checker.sv
